FILE: rtl/core/rdc_pkg.sv
// shared types and constants for the radix digit converter
// no dependencies; imported by rdc_div_serial, rdc_digit_stack, the top level and the testbench
package rdc_pkg;

   localparam int DIGIT_W = 4;
   localparam int RADIX_W = 5;

   typedef logic [DIGIT_W-1:0] digit_type;
   typedef logic [RADIX_W-1:0] radix_type;

   localparam radix_type RADIX_RESET = 5'd10;
   localparam radix_type RADIX_MIN   = 5'd2;
   localparam radix_type RADIX_MAX   = 5'd16;

   // divider status toward the sequencer
   typedef struct packed {
      logic      done;     // one-cycle pulse, pass finished
      logic      quot_nz;  // quotient of the finished pass is nonzero
      digit_type rem;      // remainder of the finished pass
   } div_status_type;

   // digit stack status toward the sequencer
   typedef struct packed {
      logic empty;
      logic almost_full;   // one free entry left
   } stack_status_type;

endpackage

FILE: rtl/core/rdc_div_serial.sv
// bit-serial restoring divider by a small radix, one quotient bit per cycle while busy
// depends on rdc_pkg
module rdc_div_serial import rdc_pkg::*; #(
   parameter int VALUE_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  load_new,
   input  logic [VALUE_BITS-1:0] din,
   input  radix_type             radix,
   output div_status_type        status
);

   localparam int CNT_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

   logic [VALUE_BITS-1:0] quot_ff, quot_in;
   digit_type             rem_ff, rem_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic                  nz_ff, nz_in;

   logic [RADIX_W-1:0]    raw;
   logic [RADIX_W-1:0]    diff;
   logic                  ge;

   assign raw  = {rem_ff, quot_ff[VALUE_BITS-1]};
   assign ge   = (raw >= radix);
   assign diff = raw - radix;

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      nz_in   = nz_ff;
      done_in = 1'b0;
      if (start) begin
         if (load_new) begin
            quot_in = din;
         end
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
         nz_in   = 1'b0;
      end else if (busy_ff) begin
         rem_in  = ge ? diff[DIGIT_W-1:0] : raw[DIGIT_W-1:0];
         quot_in = {quot_ff[VALUE_BITS-2:0], ge};
         nz_in   = nz_ff | ge;
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(VALUE_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
      nz_ff   <= nz_in;
   end

   assign status.done    = done_ff;
   assign status.quot_nz = nz_ff;
   assign status.rem     = rem_ff;

endmodule

FILE: rtl/core/rdc_digit_stack.sv
// last-in-first-out digit store with registered read
// depends on rdc_pkg
module rdc_digit_stack import rdc_pkg::*; #(
   parameter int MAX_DIGITS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  digit_type        push_digit,
   input  logic             pop,
   output digit_type        pop_digit,
   output stack_status_type status
);

   localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
   localparam int CNT_W = $clog2(MAX_DIGITS + 1);

   digit_type        mem [MAX_DIGITS];
   digit_type        rd_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] count_dec;

   assign count_dec = count_ff - 1'b1;

   always_comb begin
      count_in = count_ff;
      if (push) begin
         count_in = count_ff + 1'b1;
      end else if (pop) begin
         count_in = count_dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[count_ff[IDX_W-1:0]] <= push_digit;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rd_ff <= mem[count_dec[IDX_W-1:0]];
      end
   end

   assign pop_digit          = rd_ff;
   assign status.empty       = (count_ff == '0);
   assign status.almost_full = (count_ff == CNT_W'(MAX_DIGITS - 1));

endmodule

FILE: rtl/core/radix_digit_converter_top.sv
// radix digit converter top level: sequencer, radix register, output word
// depends on rdc_pkg, rdc_div_serial and rdc_digit_stack
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+------------------------------
//  req      | in        | req_tvalid/req_tready | value (32 bits)
//  rsp      | out       | rsp_tvalid/rsp_tready | digit (4 bits), tlast = last digit
//  csr      | in        | csr_valid/csr_ready   | radix (5 bits), 2..16 kept
//
// a value of n digits takes n passes of the serial divider, one pass per digit,
//   each pass shifting all VALUE_BITS bits of the quotient through the remainder
// digits leave most significant first; each costs a stack read and an output word
// one value at a time: req_tready is high only while the sequencer sits idle
// rsp stall simply holds the output word; nothing is lost
// synchronous active-high reset; radix returns to 10, no clearing pass on the stack
module radix_digit_converter_top import rdc_pkg::*; #(
   parameter int VALUE_BITS = 32,
   parameter int MAX_DIGITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   // req: [31:0] value
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,
   // rsp: [3:0] digit, [7:4] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,
   output logic        rsp_tlast,
   // csr: [4:0] radix
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [4:0]  csr_wdata
);

   localparam int LOAD_W = (VALUE_BITS < 32) ? VALUE_BITS : 32;

   // sequencer states
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_RD   = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;

   logic [1:0]            state_ff, state_in;
   radix_type             radix_ff, radix_in;

   logic                  div_start;
   logic                  div_load_new;
   logic [VALUE_BITS-1:0] div_din;
   div_status_type        div_stat;

   logic                  stk_push;
   logic                  stk_pop;
   digit_type             stk_digit;
   stack_status_type      stk_stat;

   logic                  req_acc;
   logic                  rsp_acc;

   // radix register, out-of-range writes ignored
   assign csr_ready = 1'b1;

   always_comb begin
      radix_in = radix_ff;
      if (csr_valid && (csr_wdata >= RADIX_MIN) && (csr_wdata <= RADIX_MAX)) begin
         radix_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= RADIX_RESET;
      end else begin
         radix_ff <= radix_in;
      end
   end

   // only the low VALUE_BITS bits of the value take part
   assign div_din = VALUE_BITS'(req_tdata[LOAD_W-1:0]);

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_acc    = rsp_tvalid && rsp_tready;

   // sequencer: divide passes push digits, then pops stream them out
   always_comb begin
      state_in     = state_ff;
      div_start    = 1'b0;
      div_load_new = 1'b0;
      stk_push     = 1'b0;
      stk_pop      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               div_start    = 1'b1;
               div_load_new = 1'b1;
               state_in     = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_stat.done) begin
               stk_push = 1'b1;
               // keep dividing while the quotient is nonzero and room is left
               if (div_stat.quot_nz && !stk_stat.almost_full) begin
                  div_start = 1'b1;
               end else begin
                  state_in = ST_RD;
               end
            end
         end
         ST_RD: begin
            stk_pop  = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_acc) begin
               state_in = stk_stat.empty ? ST_IDLE : ST_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   rdc_div_serial #(
      .VALUE_BITS (VALUE_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .load_new (div_load_new),
      .din      (div_din),
      .radix    (radix_ff),
      .status   (div_stat)
   );

   rdc_digit_stack #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_stack (
      .clock      (clock),
      .reset      (reset),
      .push       (stk_push),
      .push_digit (div_stat.rem),
      .pop        (stk_pop),
      .pop_digit  (stk_digit),
      .status     (stk_stat)
   );

   // output word: popped digit, last when the stack has drained
   assign rsp_tdata = {4'b0000, stk_digit};
   assign rsp_tlast = stk_stat.empty;

endmodule

FILE: tb/tb_radix_digit_converter_top.sv
// self-checking testbench for radix_digit_converter_top: values in, digit words out
// predicts each digit word in the testbench and compares it against the block's output
// depends on rdc_pkg and radix_digit_converter_top
module tb_radix_digit_converter_top;
   import rdc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // worst item: 32 digits, a full divider pass each plus output, with stalls, times several
   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int PHASE_ITEMS = 48;

   // one expected output word: digit plus last-digit flag
   typedef struct packed {
      digit_type digit;
      logic      last;
   } digit_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;        // [31:0] value
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;             // [3:0] digit, [7:4] zero
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [4:0]  csr_wdata = '0;        // [4:0] radix

   // radix as the block should hold it, and the digit words still owed
   radix_type      radix_model;
   digit_word_type digit_queue[$];
   int             mismatch_count = 0;
   int             cycle_count = 0;
   int             req_idle_pct = 9;
   int             rsp_idle_pct = 9;

   radix_digit_converter_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // run-away guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // receiver: random back-pressure on the digit stream
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   // split the value by repeated remainder and quotient, then queue the digits
   // most significant first; zero still gives one digit
   function automatic void predict_digits(input logic [31:0] value);
      logic [31:0] quotient;
      digit_type   stack[32];
      int          depth;
      digit_word_type word;
      quotient = value;
      depth = 0;
      do begin
         stack[depth] = digit_type'(quotient % radix_model);
         quotient = quotient / radix_model;
         depth++;
      end while (quotient != 0 && depth < 32);
      for (int i = depth - 1; i >= 0; i--) begin
         word.digit = stack[i];
         word.last = (i == 0);
         digit_queue.push_back(word);
      end
   endfunction

   // compare every accepted digit word with the oldest expected one
   always @(posedge clock) begin
      digit_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (digit_queue.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual digit %0h last %0b",
                     $time, rsp_tdata, rsp_tlast);
            mismatch_count++;
         end else begin
            want = digit_queue.pop_front();
            if (rsp_tdata !== {4'b0000, want.digit}) begin
               $display("%0t: digit mismatch, expected %0h actual %0h",
                        $time, {4'b0000, want.digit}, rsp_tdata);
               mismatch_count++;
            end
            if (rsp_tlast !== want.last) begin
               $display("%0t: last mismatch, expected %0b actual %0b",
                        $time, want.last, rsp_tlast);
               mismatch_count++;
            end
         end
      end
   end

   // offer one value, with an occasional gap first; valid stays up for the next call
   task automatic send_value(input logic [31:0] value);
      int gap;
      if ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         gap = ($urandom_range(3) == 0) ? $urandom_range(1, 80) : $urandom_range(1, 4);
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= value;
      do @(posedge clock); while (!req_tready);
      predict_digits(value);
   endtask

   // drop valid and let every owed word come out, then a short settle
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (digit_queue.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // write the radix register while idle; out-of-range values must be ignored
   task automatic write_radix(input logic [4:0] value);
      wait_idle();
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (value >= RADIX_MIN && value <= RADIX_MAX) radix_model = radix_type'(value);
   endtask

   // a power of the radix, or one off from it, within 32 bits
   function automatic logic [31:0] boundary_value(input radix_type r);
      logic [63:0] power;
      int          steps;
      power = 64'd1;
      steps = $urandom_range(0, 31);
      repeat (steps) if (power * r <= 64'hFFFF_FFFF) power = power * r;
      case ($urandom_range(2))
         0: power = power - 64'd1;
         1: if (power < 64'hFFFF_FFFF) power = power + 64'd1;
         default: ;
      endcase
      return power[31:0];
   endfunction

   function automatic logic [31:0] random_value();
      case ($urandom_range(7))
         0: return $urandom_range(0, 300);
         1: return boundary_value(radix_model);
         2: return 32'hFFFF_FFFF - $urandom_range(0, 20);
         3: return $urandom >> $urandom_range(0, 31);
         default: return $urandom;
      endcase
   endfunction

   // default radix straight out of reset: zero, one, the digit boundary, full scale
   task automatic test_default_radix();
      send_value(32'd0);
      send_value(32'd1);
      send_value(32'd9);
      send_value(32'd10);
      send_value(32'd1_000_000_000);
      send_value(32'hFFFF_FFFF);
   endtask

   // smallest and largest radix: longest and widest digits, then radix 3 at full scale
   task automatic test_radix_extremes();
      write_radix(5'd2);
      send_value(32'd0);
      send_value(32'd1);
      send_value(32'hFFFF_FFFF);
      send_value(32'h8000_0000);
      send_value(32'h5555_5555);
      write_radix(5'd16);
      send_value(32'hFFFF_FFFF);
      send_value(32'h0000_000F);
      send_value(32'h0000_0010);
      send_value(32'hDEAD_BEEF);
      write_radix(5'd3);
      send_value(32'hFFFF_FFFF);
   endtask

   // writes outside 2..16 leave the radix alone, all csr bits low and high
   task automatic test_rejected_writes();
      write_radix(5'd0);
      write_radix(5'd1);
      write_radix(5'd17);
      write_radix(5'd31);
      send_value(32'd80);
      send_value(32'd81);
      send_value(32'h7FFF_FFFF);
   endtask

   // phases of random values over several radices, with stray rejected writes
   task automatic test_random_streams();
      radix_type phase_radix[8] = '{5'd2, 5'd16, 5'd10, 5'd3, 5'd7, 5'd13, 5'd5, 5'd0};
      logic [4:0] target;
      for (int phase = 0; phase < 8; phase++) begin
         target = (phase_radix[phase] == 0) ? 5'($urandom_range(2, 16)) : phase_radix[phase];
         if ($urandom_range(2) == 0) write_radix(($urandom_range(1) == 0) ?
            5'($urandom_range(0, 1)) : 5'($urandom_range(17, 31)));
         write_radix(target);
         // one phase runs with neither side idling
         req_idle_pct = (phase == 3) ? 0 : 9;
         rsp_idle_pct = (phase == 3) ? 0 : 9;
         repeat (PHASE_ITEMS) send_value(random_value());
      end
      req_idle_pct = 9;
      rsp_idle_pct = 9;
   endtask

   initial begin
      radix_model = RADIX_RESET;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_radix();
      test_radix_extremes();
      test_rejected_writes();
      test_random_streams();
      wait_idle();
      repeat (64) @(posedge clock);
      if (mismatch_count == 0 && digit_queue.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
